/* design/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// gsr_pkg
// Types and constants shared by the group switch retry state machine.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int unsigned TreeW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SeqW  = 32;
  localparam int unsigned AttW  = 3;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TimeW-1:0] TimeoutReset = 32'd1000000;
  localparam logic [AttW-1:0]  AttLimitReset = 3'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT   = 1'b0,
    CFG_ATT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_REPLY = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_LEAVE = 2'd0,
    KIND_JOIN  = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_RSVD  = 2'd3
  } reply_kind_e;

  typedef enum logic [1:0] {
    MODE_POS   = 2'd0,
    MODE_NEG   = 2'd1,
    MODE_OTHER = 2'd2,
    MODE_RSVD  = 2'd3
  } reply_mode_e;

  localparam logic REQ_KIND_LEAVE = 1'b0;
  localparam logic REQ_KIND_JOIN  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_LEAVING = 3'b010,
    PH_JOINING = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TreeW-1:0] new_tree;
    logic [1:0]       reply_kind;
    logic [1:0]       reply_mode;
    logic [TimeW-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic             send_request;
    logic             request_kind;
    logic             request_retry;
    logic [SeqW-1:0]  request_seq;
    logic [TreeW-1:0] request_tree;
    logic             drop_subscriptions;
    logic             restore_subscriptions;
    logic             switch_done;
    logic [TreeW-1:0] active_tree;
  } out_item_t;

  typedef struct packed {
    phase_e           phase;
    logic [TreeW-1:0] current_tree;
    logic [TreeW-1:0] pending_tree;
    logic [TimeW-1:0] last_send_time;
    logic [AttW-1:0]  attempts;
    logic [SeqW-1:0]  seq_num;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] timeout_us;
    logic [AttW-1:0]  attempt_limit;
  } cfg_t;

endpackage

/* design/gsr_if.sv */
// ----------------------------------------------------------------------------
// gsr_in_if / gsr_out_if
// Valid-ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface gsr_in_if;
  logic              valid;
  logic              ready;
  gsr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gsr_out_if;
  logic               valid;
  logic               ready;
  gsr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/gsr_next.sv */
// ----------------------------------------------------------------------------
// gsr_next
// Next-state and result logic for one item of the switch protocol.
// ----------------------------------------------------------------------------
module gsr_next (
  input  gsr_pkg::state_t    state_i,
  input  gsr_pkg::cfg_t      cfg_i,
  input  gsr_pkg::in_item_t  item_i,
  output gsr_pkg::state_t    state_o,
  output gsr_pkg::out_item_t result_o
);
  import gsr_pkg::*;

  logic [SeqW-1:0]  seq_inc;
  logic [TimeW-1:0] elapsed;

  assign seq_inc = state_i.seq_num + SeqW'(1);
  assign elapsed = item_i.now_us - state_i.last_send_time;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.req_type)
      REQ_START: begin
        if (item_i.new_tree != '0 && item_i.new_tree != state_i.current_tree) begin
          state_o.pending_tree   = item_i.new_tree;
          state_o.seq_num        = seq_inc;
          state_o.last_send_time = item_i.now_us;
          state_o.attempts       = '0;
          result_o.send_request  = 1'b1;
          result_o.request_seq   = seq_inc;
          if (state_i.current_tree != '0) begin
            result_o.drop_subscriptions = 1'b1;
            result_o.request_kind       = REQ_KIND_LEAVE;
            result_o.request_tree       = state_i.current_tree;
            state_o.phase               = PH_LEAVING;
          end else begin
            state_o.current_tree  = item_i.new_tree;
            result_o.request_kind = REQ_KIND_JOIN;
            result_o.request_tree = item_i.new_tree;
            state_o.phase         = PH_JOINING;
          end
        end
      end
      REQ_REPLY: begin
        if (state_i.phase == PH_LEAVING && item_i.reply_kind == KIND_LEAVE) begin
          if (item_i.reply_mode == MODE_POS) begin
            state_o.current_tree   = state_i.pending_tree;
            state_o.seq_num        = seq_inc;
            state_o.last_send_time = item_i.now_us;
            state_o.attempts       = '0;
            state_o.phase          = PH_JOINING;
            result_o.send_request  = 1'b1;
            result_o.request_kind  = REQ_KIND_JOIN;
            result_o.request_seq   = seq_inc;
            result_o.request_tree  = state_i.pending_tree;
          end else if (item_i.reply_mode == MODE_NEG) begin
            state_o.phase = PH_IDLE;
          end
        end else if (state_i.phase == PH_JOINING && item_i.reply_kind == KIND_JOIN) begin
          if (item_i.reply_mode == MODE_POS) begin
            result_o.restore_subscriptions = 1'b1;
            state_o.phase                  = PH_IDLE;
          end else if (item_i.reply_mode == MODE_NEG) begin
            state_o.phase = PH_IDLE;
          end
        end
      end
      REQ_TICK: begin
        if (state_i.phase != PH_IDLE && elapsed >= cfg_i.timeout_us) begin
          if (state_i.attempts >= cfg_i.attempt_limit) begin
            state_o.phase = PH_IDLE;
          end else begin
            state_o.last_send_time = item_i.now_us;
            state_o.attempts       = state_i.attempts + AttW'(1);
            result_o.send_request  = 1'b1;
            result_o.request_kind  = (state_i.phase == PH_JOINING) ? REQ_KIND_JOIN
                                                                   : REQ_KIND_LEAVE;
            result_o.request_retry = 1'b1;
            result_o.request_seq   = state_i.seq_num;
            result_o.request_tree  = state_i.current_tree;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.switch_done = (state_o.phase == PH_IDLE);
    result_o.active_tree = state_o.current_tree;
  end

endmodule

/* design/group_switch_retry_fsm.sv */
// ----------------------------------------------------------------------------
// group_switch_retry_fsm
// Leave-then-join multicast tree switch with reply timeout and resend.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output is not held off, and each
// gives exactly one result item, which is held in the output register from the
// cycle after acceptance. The input is ready whenever the output register is
// empty or its item is being taken in the same cycle, so a steady flow with the
// output taken runs at one item per cycle; the only other limit is the single
// pass through the next-state logic into the state and output registers.
module group_switch_retry_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gsr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gsr_pkg::CfgW-1:0]   cfg_data_i,
  gsr_in_if.sink                     in_i,
  gsr_out_if.source                  out_o
);
  import gsr_pkg::*;

  state_t    state_q, state_d;
  cfg_t      cfg_q;
  out_item_t result_d, result_q;
  logic      out_valid_q;
  logic      accept;

  gsr_next u_next (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_i.data),
    .state_o  (state_d),
    .result_o (result_d)
  );

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us    <= TimeoutReset;
      cfg_q.attempt_limit <= AttLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT:   cfg_q.timeout_us    <= cfg_data_i[TimeW-1:0];
        CFG_ATT_LIMIT: cfg_q.attempt_limit <= cfg_data_i[AttW-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_IDLE;
      state_q.current_tree   <= '0;
      state_q.pending_tree   <= '0;
      state_q.last_send_time <= '0;
      state_q.attempts       <= '0;
      state_q.seq_num        <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

endmodule

/* bench/group_switch_retry_fsm_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_switch_retry_fsm_test
// Self-checking bench for the multicast tree switch state machine. Directed
// items cover the ignored cases, restarts, both reply outcomes and the
// timeout extremes. Random switch sequences then run under several register
// settings and idling patterns, including a long output stall. Every result
// item is compared with the prediction of a behavioural copy of the switch.
// ----------------------------------------------------------------------------
module group_switch_retry_fsm_test;
  import gsr_pkg::*;

  localparam int StallLimit = 3000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  gsr_in_if  in_if ();
  gsr_out_if out_if ();

  group_switch_retry_fsm i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Behavioural copy of the switch state and its registers.
  phase_e           sw_phase;
  logic [TreeW-1:0] sw_tree;
  logic [TreeW-1:0] sw_pending;
  logic [TimeW-1:0] sw_sent_at;
  logic [AttW-1:0]  sw_resends;
  logic [SeqW-1:0]  sw_seq;
  logic [TimeW-1:0] cfg_timeout;
  logic [AttW-1:0]  cfg_att_limit;

  out_item_t   awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned plan_timeouts = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void issue_request(inout out_item_t res, input logic kind,
                                        input logic retry);
    if (!retry) begin
      sw_seq = sw_seq + 1'b1;
    end
    res.send_request  = 1'b1;
    res.request_kind  = kind;
    res.request_retry = retry;
    res.request_seq   = sw_seq;
    res.request_tree  = sw_tree;
  endfunction

  function automatic out_item_t predict_switch(in_item_t it);
    out_item_t        res;
    logic [TimeW-1:0] waited;
    res = '0;
    waited = it.now_us - sw_sent_at;
    case (it.req_type)
      REQ_START: begin
        if (it.new_tree != '0 && it.new_tree != sw_tree) begin
          sw_pending = it.new_tree;
          if (sw_tree != '0) begin
            res.drop_subscriptions = 1'b1;
            issue_request(res, REQ_KIND_LEAVE, 1'b0);
            sw_phase = PH_LEAVING;
          end else begin
            sw_tree = sw_pending;
            issue_request(res, REQ_KIND_JOIN, 1'b0);
            sw_phase = PH_JOINING;
          end
          sw_sent_at = it.now_us;
          sw_resends = '0;
        end
      end
      REQ_REPLY: begin
        if (sw_phase == PH_LEAVING && it.reply_kind == KIND_LEAVE) begin
          if (it.reply_mode == MODE_POS) begin
            sw_tree = sw_pending;
            issue_request(res, REQ_KIND_JOIN, 1'b0);
            sw_phase   = PH_JOINING;
            sw_sent_at = it.now_us;
            sw_resends = '0;
          end else if (it.reply_mode == MODE_NEG) begin
            sw_phase = PH_IDLE;
          end
        end else if (sw_phase == PH_JOINING && it.reply_kind == KIND_JOIN) begin
          if (it.reply_mode == MODE_POS) begin
            res.restore_subscriptions = 1'b1;
            sw_phase = PH_IDLE;
          end else if (it.reply_mode == MODE_NEG) begin
            sw_phase = PH_IDLE;
          end
        end
      end
      REQ_TICK: begin
        if (sw_phase != PH_IDLE && waited >= cfg_timeout) begin
          if (sw_resends >= cfg_att_limit) begin
            sw_phase = PH_IDLE;
          end else begin
            issue_request(res, (sw_phase == PH_JOINING) ? REQ_KIND_JOIN : REQ_KIND_LEAVE,
                          1'b1);
            sw_sent_at = it.now_us;
            sw_resends = sw_resends + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.switch_done = (sw_phase == PH_IDLE);
    res.active_tree = sw_tree;
    return res;
  endfunction

  function automatic in_item_t mk(req_type_e req, logic [TreeW-1:0] tree,
                                  reply_kind_e kind, reply_mode_e mode,
                                  logic [TimeW-1:0] now);
    in_item_t it;
    it.req_type   = req;
    it.new_tree   = tree;
    it.reply_kind = kind;
    it.reply_mode = mode;
    it.now_us     = now;
    return it;
  endfunction

  // Mostly well-formed switches: a start, a planned number of timeouts and
  // then the awaited reply, with stray items mixed in.
  function automatic in_item_t make_item();
    in_item_t         it;
    int unsigned      pick;
    logic [TimeW-1:0] room;
    it.req_type   = 2'($urandom_range(3));
    it.new_tree   = $urandom;
    it.reply_kind = 2'($urandom_range(2));
    it.reply_mode = 2'($urandom_range(2));
    it.now_us     = $urandom;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return it;
    end
    if (sw_phase == PH_IDLE || pick < 25) begin
      it.req_type = REQ_START;
      case ($urandom_range(9))
        0: it.new_tree = '0;
        1: it.new_tree = '1;
        2: it.new_tree = sw_tree;
        3, 4, 5, 6: it.new_tree = $urandom_range(4, 1);
        default: ;
      endcase
      plan_timeouts = $urandom_range(8);
    end else if (plan_timeouts != 0) begin
      it.req_type = REQ_TICK;
      if ($urandom_range(4) != 0) begin
        room = ~cfg_timeout;
        it.now_us = sw_sent_at + cfg_timeout + $urandom_range((room < 3) ? room : 3);
        plan_timeouts--;
      end else begin
        it.now_us = sw_sent_at + $urandom_range(cfg_timeout - 1'b1);
      end
    end else begin
      it.req_type   = REQ_REPLY;
      it.reply_kind = (sw_phase == PH_LEAVING) ? KIND_LEAVE : KIND_JOIN;
      it.reply_mode = ($urandom_range(3) != 0) ? MODE_POS : MODE_NEG;
      plan_timeouts = $urandom_range(8);
    end
    return it;
  endfunction

  function automatic string show_item(out_item_t o);
    return {$sformatf("send=%0d kind=%0d retry=%0d seq=%h tree=%h ", o.send_request,
                      o.request_kind, o.request_retry, o.request_seq, o.request_tree),
            $sformatf("drop=%0d restore=%0d done=%0d active=%h", o.drop_subscriptions,
                      o.restore_subscriptions, o.switch_done, o.active_tree)};
  endfunction

  task automatic report_mismatch(string what, out_item_t exp, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", show_item(exp));
      $display("  actual   %s", show_item(got));
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t exp;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (awaited_results.size() == 0) begin
        report_mismatch("result item with none awaited", '0, got);
      end else begin
        exp = awaited_results.pop_front();
        if (got.send_request !== exp.send_request ||
            got.request_kind !== exp.request_kind ||
            got.request_retry !== exp.request_retry ||
            got.request_seq !== exp.request_seq ||
            got.request_tree !== exp.request_tree ||
            got.drop_subscriptions !== exp.drop_subscriptions ||
            got.restore_subscriptions !== exp.restore_subscriptions ||
            got.switch_done !== exp.switch_done ||
            got.active_tree !== exp.active_tree) begin
          report_mismatch("result item mismatch", exp, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver honours a requested hold-off before returning to random idling.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = item;
    do @(posedge clk_i); while (!in_if.ready);
    awaited_results = {awaited_results, predict_switch(item)};
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_TIMEOUT:   cfg_timeout = value;
      CFG_ATT_LIMIT: cfg_att_limit = value[AttW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [TimeW-1:0] timeout, logic [AttW-1:0] limit);
    drain_results();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_ATT_LIMIT, CfgW'(limit));
  endtask

  task automatic test_directed_switch();
    send_item(mk(REQ_REPLY, '0, KIND_LEAVE, MODE_POS, '0));
    send_item(mk(REQ_TICK, '0, KIND_OTHER, MODE_OTHER, '1));
    send_item(mk(REQ_START, '0, KIND_OTHER, MODE_OTHER, 32'd3));
    send_item(mk(REQ_START, '1, KIND_OTHER, MODE_OTHER, '0));
    send_item(mk(REQ_START, '1, KIND_JOIN, MODE_POS, 32'd5));
    send_item(mk(REQ_TICK, '0, KIND_LEAVE, MODE_POS, 32'd999999));
    send_item(mk(REQ_TICK, '0, KIND_LEAVE, MODE_POS, 32'd1000000));
    send_item(mk(REQ_REPLY, '0, KIND_OTHER, MODE_POS, '0));
    send_item(mk(REQ_REPLY, '0, KIND_JOIN, MODE_OTHER, '0));
    send_item(mk(REQ_REPLY, '0, KIND_LEAVE, MODE_POS, '0));
    send_item(mk(REQ_REPLY, '0, KIND_JOIN, MODE_POS, '0));
    send_item(mk(REQ_START, 32'd1, KIND_LEAVE, MODE_NEG, 32'hFFFF_FFF0));
    send_item(mk(REQ_NONE, '1, KIND_RSVD, MODE_RSVD, '1));
    send_item(mk(REQ_REPLY, '0, KIND_LEAVE, MODE_NEG, '0));
    send_item(mk(REQ_START, 32'd5, KIND_OTHER, MODE_OTHER, 32'd7));
    send_item(mk(REQ_START, 32'd6, KIND_OTHER, MODE_OTHER, 32'd8));
    send_item(mk(REQ_REPLY, '0, KIND_LEAVE, MODE_POS, 32'd100));
    send_item(mk(REQ_REPLY, '0, KIND_JOIN, MODE_NEG, '0));
  endtask

  // Longest timeout with wrapped elapsed time, then abandonment at a limit of one.
  task automatic test_timeout_extremes();
    configure('1, 3'd1);
    send_item(mk(REQ_START, 32'd9, KIND_OTHER, MODE_OTHER, 32'd5));
    send_item(mk(REQ_TICK, '0, KIND_OTHER, MODE_OTHER, 32'd3));
    send_item(mk(REQ_TICK, '0, KIND_OTHER, MODE_OTHER, 32'd4));
    send_item(mk(REQ_TICK, '0, KIND_OTHER, MODE_OTHER, 32'd3));
  endtask

  task automatic test_random(int unsigned count, logic [TimeW-1:0] timeout,
                             logic [AttW-1:0] limit, int unsigned s_idle,
                             int unsigned r_idle);
    configure(timeout, limit);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_item(make_item());
  endtask

  // The output is held off while items keep coming, so the input must stall.
  task automatic test_output_stall();
    configure(TimeoutReset, AttLimitReset);
    send_idle_pct = 0;
    recv_idle_pct = 10;
    hold_request  = 200;
    repeat (120) send_item(make_item());
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TIMEOUT;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    sw_phase      = PH_IDLE;
    sw_tree       = '0;
    sw_pending    = '0;
    sw_sent_at    = '0;
    sw_resends    = '0;
    sw_seq        = '0;
    cfg_timeout   = TimeoutReset;
    cfg_att_limit = AttLimitReset;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_switch();
    test_timeout_extremes();
    test_random(420, 32'd1, 3'd1, 8, 53);
    test_random(420, '1, 3'd7, 53, 8);
    test_random(420, $urandom_range(1000, 1), 3'($urandom_range(7, 1)), 0, 0);
    test_output_stall();

    drain_results();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* group_switch_retry_fsm.f */
design/gsr_pkg.sv
design/gsr_if.sv
design/gsr_next.sv
design/group_switch_retry_fsm.sv
bench/group_switch_retry_fsm_test.sv
